FILE: rtl/jsv_pkg.sv
// types, constants and helper functions shared by the json stream validator
package jsv_pkg;

  typedef enum logic [4:0] {
    P_START, P_VALUE, P_ARR_OPEN, P_OBJ_OPEN, P_KEY, P_COLON, P_AFTER,
    P_STR, P_ESC, P_HEX, P_LOW_BS, P_LOW_U, P_HEX_LOW,
    P_TRUE, P_FALSE, P_NULL,
    P_MINUS, P_ZERO, P_INT, P_DOT, P_FRAC, P_E, P_ESIGN, P_EXP,
    P_ERR
  } phase_t;

  localparam logic [2:0] EV_CONSUMED = 3'd0;
  localparam logic [2:0] EV_BYTE     = 3'd1;
  localparam logic [2:0] EV_ERROR    = 3'd2;
  localparam logic [2:0] EV_VALID    = 3'd3;
  localparam logic [2:0] EV_INVALID  = 3'd4;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [5:0] MAX_DEPTH_RESET = 6'd32;

  localparam int QDEPTH = 4;

  // one input transaction's worth of results
  typedef struct packed {
    logic [2:0]      ev;
    logic [1:0]      cnt;
    logic [3:0][7:0] bytes;
    logic            key;
    logic [6:0]      nest;
  } bundle_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
    return v;
  endfunction

  function automatic logic [7:0] lit_char(input phase_t ph, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (ph)
      P_TRUE: begin
        case (pos)
          3'd0: c = 8'h74;
          3'd1: c = 8'h72;
          3'd2: c = 8'h75;
          3'd3: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      P_FALSE: begin
        case (pos)
          3'd0: c = 8'h66;
          3'd1: c = 8'h61;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h73;
          3'd4: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      P_NULL: begin
        case (pos)
          3'd0: c = 8'h6E;
          3'd1: c = 8'h75;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input phase_t ph);
    return (ph == P_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

FILE: rtl/json_stream_validator.sv
// top level of the json stream validator
//
// input channel: push/full carries one transaction per document byte
// (kind 0, text_byte) or an end marker (kind 1). results come out on
// empty/pop, oldest first; each input gives one to four results and the
// final one of them has last set. the user writes max_depth through
// cfg_we/cfg_data only while the block is idle; the block does not enforce it.
//
// an accepted input is written into the bundle queue, then loaded into
// the output register that drives the output ports; it waits in the
// queue while that register still holds results of earlier inputs.
// throughput: one input per cycle while the output side keeps up; the
// output side gives one result per cycle while the receiver pops, so a
// byte that decodes to an n-byte utf-8 sequence gives n results.
// a four-entry bundle queue sits between the parser and the output, so
// full rises only when that queue has filled because the output side fell
// behind, from receiver stalls or multi-result inputs.
//
// reset clears the parser, the queue and the output; max_depth returns to
// 32. the container stack needs no clearing since it is read only where
// written. an end marker also returns the parser to its start state.
module json_stream_validator import jsv_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       kind,
  input  logic [7:0] text_byte,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] event_res,
  output logic [7:0] data,
  output logic       in_key,
  output logic [6:0] nest_level,
  output logic       last,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data
);

  logic    accept;
  bundle_t fe_bundle, q_data;
  logic    q_rd, q_avail;

  assign accept = push && !full;

  jsv_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .kind     (kind),
    .text_byte(text_byte),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .bundle   (fe_bundle)
  );

  jsv_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (accept),
    .wdata(fe_bundle),
    .rd   (q_rd),
    .rdata(q_data),
    .full (full),
    .avail(q_avail)
  );

  jsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_data    (q_data),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .event_res (event_res),
    .data      (data),
    .in_key    (in_key),
    .nest_level(nest_level),
    .last      (last)
  );

endmodule

FILE: rtl/jsv_front.sv
// front end: accepts bytes, runs the grammar state machine and builds result bundles
module jsv_front import jsv_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       kind,
  input  logic [7:0] text_byte,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  output bundle_t    bundle
);

  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  logic [5:0]    max_depth;
  phase_t        phase, phase_next;
  logic [CW-1:0] count, count_next;
  logic          top, top_next;
  logic          below;
  logic [15:0]   hex_accum, hex_accum_next;
  logic [1:0]    hex_seen, hex_seen_next;
  logic [9:0]    pend, pend_next;
  logic [2:0]    lit_pos, lit_pos_next;
  logic [1:0]    bom, bom_next;
  logic          error, error_next;
  logic          key, key_next;

  logic          stack_mem [STACK_DEPTH];
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic          st_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth <= MAX_DEPTH_RESET;
    end else if (cfg_we) begin
      max_depth <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_START;
      count     <= '0;
      hex_accum <= '0;
      hex_seen  <= '0;
      pend      <= '0;
      lit_pos   <= '0;
      bom       <= '0;
      error     <= 1'b0;
      key       <= 1'b0;
    end else begin
      phase     <= phase_next;
      count     <= count_next;
      hex_accum <= hex_accum_next;
      hex_seen  <= hex_seen_next;
      pend      <= pend_next;
      lit_pos   <= lit_pos_next;
      bom       <= bom_next;
      error     <= error_next;
      key       <= key_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  // entry below the top is read ahead so a close can restore it at once
  assign st_raddr = AW'(count_next - CW'(2));

  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    below <= stack_mem[st_raddr];
  end

  always_comb begin
    phase_t          ph;
    logic            err;
    logic            do_value, do_push, push_obj, do_pop, do_utf;
    logic [20:0]     cp;
    logic [15:0]     cp16;
    logic [4:0]      d;
    logic [2:0]      nout;
    logic [3:0][7:0] ob;
    logic            is_e, ok;

    phase_next     = phase;
    count_next     = count;
    top_next       = top;
    hex_accum_next = hex_accum;
    hex_seen_next  = hex_seen;
    pend_next      = pend;
    lit_pos_next   = lit_pos;
    bom_next       = bom;
    error_next     = error;
    key_next       = key;
    st_we          = 1'b0;
    st_waddr       = count[AW-1:0];
    st_wdata       = 1'b0;
    ph             = phase;
    err            = 1'b0;
    do_value       = 1'b0;
    do_push        = 1'b0;
    push_obj       = 1'b0;
    do_pop         = 1'b0;
    do_utf         = 1'b0;
    cp             = '0;
    cp16           = '0;
    d              = '0;
    nout           = '0;
    ob             = '0;
    is_e           = (text_byte == 8'h65) || (text_byte == 8'h45);
    ok             = 1'b0;
    bundle         = '0;

    if (accept && kind == KIND_END) begin
      ok = !error && (count == '0) &&
           (phase == P_AFTER || phase == P_ZERO || phase == P_INT ||
            phase == P_FRAC || phase == P_EXP);
      phase_next     = P_START;
      count_next     = '0;
      hex_accum_next = '0;
      hex_seen_next  = '0;
      pend_next      = '0;
      lit_pos_next   = '0;
      bom_next       = '0;
      error_next     = 1'b0;
      key_next       = 1'b0;
      bundle.ev      = ok ? EV_VALID : EV_INVALID;
    end else if (accept && !error) begin
      // bytes that fall through to another state
      if (ph == P_START && bom == 2'd0 && text_byte != 8'hEF) begin
        bom_next = 2'd3;
        ph = P_VALUE;
      end
      if ((ph == P_ZERO && text_byte != 8'h2E && !is_e) ||
          (ph == P_INT && !is_digit(text_byte) && text_byte != 8'h2E && !is_e) ||
          (ph == P_FRAC && !is_digit(text_byte) && !is_e) ||
          (ph == P_EXP && !is_digit(text_byte))) begin
        ph = P_AFTER;
      end
      phase_next = ph;

      case (ph)
        P_START: begin
          if (bom == 2'd0) begin
            bom_next = 2'd1;
          end else if (bom == 2'd1) begin
            if (text_byte != 8'hBB) err = 1'b1;
            else bom_next = 2'd2;
          end else begin
            if (text_byte != 8'hBF) err = 1'b1;
            else begin
              bom_next = 2'd3;
              phase_next = P_VALUE;
            end
          end
        end
        P_VALUE: begin
          if (!is_ws(text_byte)) do_value = 1'b1;
        end
        P_ARR_OPEN: begin
          if (is_ws(text_byte)) begin
          end else if (text_byte == 8'h5D) do_pop = 1'b1;
          else do_value = 1'b1;
        end
        P_OBJ_OPEN: begin
          if (is_ws(text_byte)) begin
          end else if (text_byte == 8'h7D) do_pop = 1'b1;
          else if (text_byte == 8'h22) begin
            key_next = 1'b1;
            phase_next = P_STR;
          end else err = 1'b1;
        end
        P_KEY: begin
          if (is_ws(text_byte)) begin
          end else if (text_byte == 8'h22) begin
            key_next = 1'b1;
            phase_next = P_STR;
          end else err = 1'b1;
        end
        P_COLON: begin
          if (is_ws(text_byte)) begin
          end else if (text_byte == 8'h3A) phase_next = P_VALUE;
          else err = 1'b1;
        end
        P_AFTER: begin
          if (is_ws(text_byte)) begin
          end else if (count == '0) err = 1'b1;
          else if (text_byte == 8'h2C) phase_next = top ? P_KEY : P_VALUE;
          else if ((text_byte == 8'h7D && top) || (text_byte == 8'h5D && !top)) do_pop = 1'b1;
          else err = 1'b1;
        end
        P_STR: begin
          if (text_byte == 8'h22) begin
            if (key) begin
              key_next = 1'b0;
              phase_next = P_COLON;
            end else phase_next = P_AFTER;
          end else if (text_byte < 8'h20) err = 1'b1;
          else if (text_byte == 8'h5C) phase_next = P_ESC;
          else begin
            ob[0] = text_byte;
            nout = 3'd1;
          end
        end
        P_ESC: begin
          phase_next = P_STR;
          nout = 3'd1;
          case (text_byte)
            8'h22, 8'h5C, 8'h2F: ob[0] = text_byte;
            8'h62: ob[0] = 8'h08;
            8'h66: ob[0] = 8'h0C;
            8'h6E: ob[0] = 8'h0A;
            8'h72: ob[0] = 8'h0D;
            8'h74: ob[0] = 8'h09;
            8'h75: begin
              nout = 3'd0;
              hex_accum_next = '0;
              hex_seen_next = '0;
              phase_next = P_HEX;
            end
            default: begin
              nout = 3'd0;
              err = 1'b1;
            end
          endcase
        end
        P_HEX, P_HEX_LOW: begin
          d = hex_val(text_byte);
          if (d[4]) err = 1'b1;
          else begin
            cp16 = {hex_accum[11:0], d[3:0]};
            hex_accum_next = cp16;
            if (hex_seen != 2'd3) hex_seen_next = hex_seen + 2'd1;
            else begin
              hex_seen_next = '0;
              if (ph == P_HEX) begin
                if (cp16 >= 16'hD800 && cp16 <= 16'hDBFF) begin
                  pend_next = cp16[9:0];
                  phase_next = P_LOW_BS;
                end else if (cp16 >= 16'hDC00 && cp16 <= 16'hDFFF) err = 1'b1;
                else begin
                  cp = {5'd0, cp16};
                  do_utf = 1'b1;
                  phase_next = P_STR;
                end
              end else begin
                if (cp16 < 16'hDC00 || cp16 > 16'hDFFF) err = 1'b1;
                else begin
                  cp = 21'h10000 + {1'b0, pend, cp16[9:0]};
                  pend_next = '0;
                  do_utf = 1'b1;
                  phase_next = P_STR;
                end
              end
            end
          end
        end
        P_LOW_BS: begin
          if (text_byte != 8'h5C) err = 1'b1;
          else phase_next = P_LOW_U;
        end
        P_LOW_U: begin
          if (text_byte != 8'h75) err = 1'b1;
          else begin
            hex_accum_next = '0;
            hex_seen_next = '0;
            phase_next = P_HEX_LOW;
          end
        end
        P_TRUE, P_FALSE, P_NULL: begin
          if (lit_pos >= lit_len(ph)) err = 1'b1;
          else if (text_byte != lit_char(ph, lit_pos)) err = 1'b1;
          else if (lit_pos + 3'd1 == lit_len(ph)) begin
            lit_pos_next = '0;
            phase_next = P_AFTER;
          end else lit_pos_next = lit_pos + 3'd1;
        end
        P_MINUS: begin
          if (text_byte == 8'h30) phase_next = P_ZERO;
          else if (is_digit(text_byte)) phase_next = P_INT;
          else err = 1'b1;
        end
        P_ZERO, P_INT: begin
          if (text_byte == 8'h2E) phase_next = P_DOT;
          else if (is_e) phase_next = P_E;
        end
        P_DOT: begin
          if (!is_digit(text_byte)) err = 1'b1;
          else phase_next = P_FRAC;
        end
        P_FRAC: begin
          if (is_e) phase_next = P_E;
        end
        P_E: begin
          if (text_byte == 8'h2B || text_byte == 8'h2D) phase_next = P_ESIGN;
          else if (!is_digit(text_byte)) err = 1'b1;
          else phase_next = P_EXP;
        end
        P_ESIGN: begin
          if (!is_digit(text_byte)) err = 1'b1;
          else phase_next = P_EXP;
        end
        P_EXP: begin
        end
        default: err = 1'b1;
      endcase

      if (do_value) begin
        if (CMPW'(count) > CMPW'(max_depth)) err = 1'b1;
        else if (text_byte == 8'h7B) begin
          do_push = 1'b1;
          push_obj = 1'b1;
        end else if (text_byte == 8'h5B) do_push = 1'b1;
        else if (text_byte == 8'h22) begin
          key_next = 1'b0;
          phase_next = P_STR;
        end else if (text_byte == 8'h74) begin
          phase_next = P_TRUE;
          lit_pos_next = 3'd1;
        end else if (text_byte == 8'h66) begin
          phase_next = P_FALSE;
          lit_pos_next = 3'd1;
        end else if (text_byte == 8'h6E) begin
          phase_next = P_NULL;
          lit_pos_next = 3'd1;
        end else if (text_byte == 8'h2D) phase_next = P_MINUS;
        else if (text_byte == 8'h30) phase_next = P_ZERO;
        else if (text_byte >= 8'h31 && text_byte <= 8'h39) phase_next = P_INT;
        else err = 1'b1;
      end

      if (do_push) begin
        if (count == CW'(STACK_DEPTH)) err = 1'b1;
        else begin
          st_we = 1'b1;
          st_wdata = push_obj;
          top_next = push_obj;
          count_next = count + CW'(1);
          phase_next = push_obj ? P_OBJ_OPEN : P_ARR_OPEN;
        end
      end

      if (do_pop) begin
        if (count == '0) err = 1'b1;
        else begin
          count_next = count - CW'(1);
          top_next = below;
          phase_next = P_AFTER;
        end
      end

      if (do_utf) begin
        if (cp < 21'h80) begin
          nout = 3'd1;
          ob[0] = cp[7:0];
        end else if (cp < 21'h800) begin
          nout = 3'd2;
          ob[0] = {3'b110, cp[10:6]};
          ob[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
          nout = 3'd3;
          ob[0] = {4'b1110, cp[15:12]};
          ob[1] = {2'b10, cp[11:6]};
          ob[2] = {2'b10, cp[5:0]};
        end else begin
          nout = 3'd4;
          ob[0] = {5'b11110, cp[20:18]};
          ob[1] = {2'b10, cp[17:12]};
          ob[2] = {2'b10, cp[11:6]};
          ob[3] = {2'b10, cp[5:0]};
        end
      end

      if (err) begin
        st_we = 1'b0;
        error_next = 1'b1;
        phase_next = P_ERR;
        key_next = 1'b0;
        count_next = count;
        top_next = top;
        bundle.ev = EV_ERROR;
      end else if (nout != 3'd0) begin
        bundle.ev = EV_BYTE;
        bundle.cnt = 2'(nout - 3'd1);
        bundle.bytes = ob;
        bundle.key = key;
      end else begin
        bundle.ev = EV_CONSUMED;
      end
      bundle.nest = 7'(count_next);
    end else begin
      bundle.ev = EV_CONSUMED;
      bundle.nest = 7'(count);
    end
  end

endmodule

FILE: rtl/jsv_queue.sv
// short bundle queue between the front end and the result sequencer
module jsv_queue import jsv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  bundle_t wdata,
  input  logic    rd,
  output bundle_t rdata,
  output logic    full,
  output logic    avail
);

  localparam int PW = $clog2(QDEPTH);

  bundle_t       slots [QDEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   fill;

  assign full  = (fill == (PW+1)'(QDEPTH));
  assign avail = (fill != '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr) wptr <= wptr + PW'(1);
      if (rd) rptr <= rptr + PW'(1);
      if (wr && !rd) fill <= fill + (PW+1)'(1);
      else if (rd && !wr) fill <= fill - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

FILE: rtl/jsv_back.sv
// back end: holds one bundle and hands out its results one transaction at a time
module jsv_back import jsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  bundle_t    q_data,
  output logic       q_rd,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] event_res,
  output logic [7:0] data,
  output logic       in_key,
  output logic [6:0] nest_level,
  output logic       last
);

  bundle_t    cur;
  logic       vld;
  logic [1:0] idx;
  logic       taken;

  assign empty      = !vld;
  assign last       = (idx == cur.cnt);
  assign event_res  = cur.ev;
  assign data       = cur.bytes[idx];
  assign in_key     = cur.key;
  assign nest_level = cur.nest;
  assign taken      = vld && pop;
  assign q_rd       = q_avail && (!vld || (taken && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      idx <= '0;
    end else if (q_rd) begin
      vld <= 1'b1;
      idx <= '0;
    end else if (taken) begin
      if (last) vld <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

endmodule

FILE: rtl/jsv_checker.sv
// port-level assertions for the json stream validator and their bind
module jsv_checker import jsv_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [2:0] event_res,
  input logic [7:0] data,
  input logic [6:0] nest_level,
  input logic       last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results visible after reset");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> !empty)
    else $error("transaction ended before its last result");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_res != EV_BYTE) |-> last)
    else $error("non-byte result not marked last");

  a_end_level: assert property (@(posedge clk) disable iff (rst)
    (!empty && (event_res == EV_VALID || event_res == EV_INVALID)) |-> nest_level == 7'd0)
    else $error("end result with nonzero nesting");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(event_res) && $stable(data) && $stable(last)))
    else $error("waiting result changed");

endmodule

bind json_stream_validator jsv_checker u_jsv_checker (.*);
